// ===== src/b64_pkg.sv =====
package b64_pkg;

  // character codes
  localparam logic [7:0] PadChar   = 8'h3D;
  localparam logic [7:0] CrChar    = 8'h0D;
  localparam logic [7:0] LfChar    = 8'h0A;
  localparam logic [7:0] UpperBase = 8'h41;
  localparam logic [7:0] LowerBase = 8'h61;
  localparam logic [7:0] DigitBase = 8'h30;
  localparam logic [7:0] PlusChar  = 8'h2B;
  localparam logic [7:0] SlashChar = 8'h2F;

  // configuration port
  localparam int unsigned AddrW = 3;
  localparam logic        RegDirection = 1'b0;
  localparam logic        DirEncode = 1'b0;

  // result queue depth: one waiting result plus one full encoded group
  localparam int unsigned QDepth = 5;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
  } res_t;

  typedef struct packed {
    logic [23:0]    group_bits;
    logic [2:0]     group_count;
    logic [2:0]     res_count;
    res_t [3:0]     res;
  } step_t;

  // sextet to base64 alphabet character
  function automatic logic [7:0] sextet_to_char(input logic [5:0] s);
    logic [7:0] c;
    if (s < 6'd26) begin
      c = UpperBase + {2'b00, s};
    end else if (s < 6'd52) begin
      c = LowerBase + {2'b00, s - 6'd26};
    end else if (s < 6'd62) begin
      c = DigitBase + {2'b00, s - 6'd52};
    end else if (s == 6'd62) begin
      c = PlusChar;
    end else begin
      c = SlashChar;
    end
    return c;
  endfunction

  // alphabet character to sextet, anything else maps to zero
  function automatic logic [5:0] char_to_sextet(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c inside {[8'h41:8'h5A]}) begin
      d = c - UpperBase;
    end else if (c inside {[8'h61:8'h7A]}) begin
      d = c - LowerBase + 8'd26;
    end else if (c inside {[8'h30:8'h39]}) begin
      d = c - DigitBase + 8'd52;
    end else if (c == PlusChar) begin
      d = 8'd62;
    end else if (c == SlashChar) begin
      d = 8'd63;
    end
    return d[5:0];
  endfunction

endpackage

// ===== src/b64_if.sv =====
interface b64_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface b64_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;

  modport source (output valid, output out_byte, output out_valid, output out_last,
                  input ready);
  modport sink (input valid, input out_byte, input out_valid, input out_last,
                output ready);
endinterface

// ===== src/b64_step.sv =====
module b64_step import b64_pkg::*; (
  input  logic        direction_i,
  input  logic [23:0] group_bits_i,
  input  logic [2:0]  group_count_i,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output step_t       step_o
);

  // per-item encode / decode step
  always_comb begin
    logic [23:0] gb_new;
    logic [23:0] triple;
    logic [2:0]  cnt_inc;
    logic [2:0]  n;
    logic        skip;
    logic        have;
    logic [7:0]  dbyte;

    step_o  = '0;
    gb_new  = '0;
    triple  = '0;
    cnt_inc = '0;
    n       = '0;
    skip    = 1'b0;
    have    = 1'b0;
    dbyte   = '0;

    if (direction_i == DirEncode) begin
      // gather bytes, flush four characters on a full group or on last
      gb_new  = {group_bits_i[15:0], in_byte_i};
      cnt_inc = group_count_i + 3'd1;
      step_o.group_bits  = gb_new;
      step_o.group_count = cnt_inc;
      if (cnt_inc >= 3'd3 || in_last_i) begin
        n = (cnt_inc > 3'd3) ? 3'd3 : cnt_inc;
        case (n)
          3'd0:    triple = '0;
          3'd1:    triple = {gb_new[7:0], 16'h0000};
          3'd2:    triple = {gb_new[15:0], 8'h00};
          default: triple = gb_new;
        endcase
        for (int i = 0; i < 4; i++) begin
          step_o.res[i].out_byte  = (3'(i) <= n) ? sextet_to_char(triple[18-6*i +: 6])
                                                 : PadChar;
          step_o.res[i].out_valid = 1'b1;
          step_o.res[i].out_last  = in_last_i && (i == 3);
        end
        step_o.res_count   = 3'd4;
        step_o.group_bits  = '0;
        step_o.group_count = '0;
      end
    end else begin
      // pad and line breaks add no bits
      skip = (in_byte_i == PadChar) || (in_byte_i == CrChar) || (in_byte_i == LfChar);
      step_o.group_bits  = group_bits_i;
      step_o.group_count = group_count_i;
      if (!skip) begin
        gb_new  = {group_bits_i[17:0], char_to_sextet(in_byte_i)};
        cnt_inc = group_count_i + 3'd1;
        step_o.group_bits  = gb_new;
        step_o.group_count = cnt_inc;
        if (cnt_inc == 3'd2) begin
          have  = 1'b1;
          dbyte = gb_new[11:4];
        end else if (cnt_inc == 3'd3) begin
          have  = 1'b1;
          dbyte = gb_new[9:2];
        end else if (cnt_inc inside {[3'd4:3'd7]}) begin
          have  = 1'b1;
          dbyte = gb_new[7:0];
          step_o.group_bits  = '0;
          step_o.group_count = '0;
        end
      end
      // one byte, or a bare end marker on a last item with no byte
      if (have || in_last_i) begin
        step_o.res_count        = 3'd1;
        step_o.res[0].out_byte  = have ? dbyte : 8'h00;
        step_o.res[0].out_valid = have;
        step_o.res[0].out_last  = in_last_i;
      end
      if (in_last_i) begin
        step_o.group_bits  = '0;
        step_o.group_count = '0;
      end
    end
  end

endmodule

// ===== src/base64_codec_top.sv =====
// base64 stream codec, direction set by the direction register
// (0: bytes to base64 text, 1: base64 text to bytes).
// in_i takes one byte or character per transfer with in_last on the final item
// of a stream. out_o gives one result per transfer: out_byte, out_valid (low for
// a bare end marker) and out_last on the final result of the stream.
// Results of an accepted item are registered into the result queue behind any
// that wait. Throughput: decoding takes one item per cycle while out_o does not
// stall. Encoding turns three bytes into four characters on the single-result
// output, so input is held back while the five-entry result queue drains; the
// queue accepts an item while it holds at most one result.
// When out_o stalls, results wait in the queue and in_i.ready drops once more
// than one result waits; no result is lost.
// The APB port writes direction at byte address 0; a direction write clears a
// partial group. Reset selects encoding and empties the queue and the group state.
module base64_codec_top import b64_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  b64_in_if.sink            in_i,
  b64_out_if.source         out_o
);

  logic                  dir_q;
  logic [23:0]           gb_q;
  logic [2:0]            gc_q;
  res_t [QDepth-1:0]     q_q, q_d;
  logic [2:0]            cnt_q, cnt_d;
  logic [2:0]            base;
  logic                  cfg_we;
  logic                  in_fire;
  logic                  out_fire;
  logic                  out_valid_w;
  step_t                 step;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == RegDirection);
  assign prdata = (paddr[2] == RegDirection) ? {31'b0, dir_q} : 32'b0;

  // handshakes
  assign in_i.ready    = (cnt_q <= 3'd1);
  assign in_fire       = in_i.valid && in_i.ready;
  assign out_valid_w   = (cnt_q != 3'd0);
  assign out_fire      = out_valid_w && out_o.ready;
  assign out_o.valid     = out_valid_w;
  assign out_o.out_byte  = q_q[0].out_byte;
  assign out_o.out_valid = q_q[0].out_valid;
  assign out_o.out_last  = q_q[0].out_last;

  b64_step u_step (
    .direction_i   (dir_q),
    .group_bits_i  (gb_q),
    .group_count_i (gc_q),
    .in_byte_i     (in_i.in_byte),
    .in_last_i     (in_i.in_last),
    .step_o        (step)
  );

  // result queue: shift out at the head, append new results behind
  always_comb begin
    base = out_fire ? cnt_q - 3'd1 : cnt_q;
    for (int i = 0; i < QDepth - 1; i++) begin
      q_d[i] = out_fire ? q_q[i+1] : q_q[i];
    end
    q_d[QDepth-1] = q_q[QDepth-1];
    for (int i = 0; i < QDepth; i++) begin
      for (int j = 0; j < 4; j++) begin
        if (in_fire && (3'(j) < step.res_count) && (base + 3'(j) == 3'(i))) begin
          q_d[i] = step.res[j];
        end
      end
    end
    cnt_d = base + (in_fire ? step.res_count : 3'd0);
  end

  // control and group state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= DirEncode;
      gb_q  <= '0;
      gc_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (cfg_we) begin
        dir_q <= pwdata[0];
        gb_q  <= '0;
        gc_q  <= '0;
      end else if (in_fire) begin
        gb_q <= step.group_bits;
        gc_q <= step.group_count;
      end
    end
  end

  // queue payload
  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

`ifndef SYNTHESIS
  a_queue_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(QDepth))
    else $error("result queue overflow");

  a_last_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.in_last |=> cnt_q != 3'd0)
    else $error("last item produced no result");

  a_last_clears_group : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.in_last |=> gc_q == 3'd0 && gb_q == 24'd0)
    else $error("group state not cleared at end of stream");
`endif

endmodule

// ===== verif/base64_codec_top_test.sv =====
`timescale 1ns / 100ps

module base64_codec_top_test;
  import b64_pkg::*;

  localparam logic DirDecode = ~DirEncode;
  localparam logic [AddrW-1:0] DirAddr   = AddrW'({RegDirection, 2'b00});
  localparam logic [AddrW-1:0] SpareAddr = AddrW'(4);
  localparam logic [8*64-1:0]  Alphabet  =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned RunLimitNs   = 3_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  b64_in_if  in_bus ();
  b64_out_if out_bus ();

  base64_codec_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_bus),
    .out_o   (out_bus)
  );

  // predicted codec state
  logic        cur_dir;
  logic [23:0] grp_bits;
  logic [2:0]  grp_cnt;
  res_t        coded_q[$];

  int err_cnt;
  bit gaps_on;
  int stall_left;
  int hold_left;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #(RunLimitNs);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [7:0] sextet_char(input logic [5:0] s);
    return Alphabet[8*(63 - int'(s)) +: 8];
  endfunction

  // characters outside the alphabet give zero
  function automatic logic [5:0] char_sextet(input logic [7:0] c);
    logic [5:0] s;
    s = '0;
    for (int i = 0; i < 64; i++) begin
      if (sextet_char(6'(i)) == c) begin
        s = 6'(i);
      end
    end
    return s;
  endfunction

  task automatic push_res(input logic [7:0] ob, input logic ov, input logic ol);
    res_t r;
    r.out_byte  = ob;
    r.out_valid = ov;
    r.out_last  = ol;
    coded_q.push_back(r);
  endtask

  // expected results of one accepted transfer
  task automatic apply_codec(input logic [7:0] b, input logic last);
    logic [23:0] triple;
    int          n;
    logic [7:0]  ob;
    logic        have;
    if (cur_dir == DirEncode) begin
      grp_bits = {grp_bits[15:0], b};
      grp_cnt  = grp_cnt + 3'd1;
      if (grp_cnt >= 3'd3 || last) begin
        n = int'(grp_cnt);
        triple = grp_bits << (8 * (3 - n));
        for (int i = 0; i < 4; i++) begin
          push_res((i <= n) ? sextet_char(triple[18 - 6*i +: 6]) : PadChar, 1'b1,
                   last && i == 3);
        end
        grp_bits = '0;
        grp_cnt  = '0;
      end
    end else begin
      have = 1'b0;
      ob   = '0;
      // pad and line breaks add no bits
      if (!(b inside {PadChar, CrChar, LfChar})) begin
        grp_bits = {grp_bits[17:0], char_sextet(b)};
        grp_cnt  = grp_cnt + 3'd1;
        if (grp_cnt == 3'd2) begin
          ob   = grp_bits[11:4];
          have = 1'b1;
        end else if (grp_cnt == 3'd3) begin
          ob   = grp_bits[9:2];
          have = 1'b1;
        end else if (grp_cnt == 3'd4) begin
          ob       = grp_bits[7:0];
          have     = 1'b1;
          grp_bits = '0;
          grp_cnt  = '0;
        end
      end
      if (have) begin
        push_res(ob, 1'b1, last);
      end else if (last) begin
        push_res(8'h00, 1'b0, 1'b1);
      end
      if (last) begin
        grp_bits = '0;
        grp_cnt  = '0;
      end
    end
  endtask

  // result checker
  initial begin
    res_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_bus.valid && out_bus.ready) begin
        if (coded_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result: byte %h valid %b last %b", $time,
                   out_bus.out_byte, out_bus.out_valid, out_bus.out_last);
        end else begin
          want = coded_q.pop_front();
          if (out_bus.out_byte !== want.out_byte) begin
            err_cnt++;
            $display("%0t: out_byte expected %h actual %h", $time, want.out_byte,
                     out_bus.out_byte);
          end
          if (out_bus.out_valid !== want.out_valid) begin
            err_cnt++;
            $display("%0t: out_valid expected %b actual %b", $time, want.out_valid,
                     out_bus.out_valid);
          end
          if (out_bus.out_last !== want.out_last) begin
            err_cnt++;
            $display("%0t: out_last expected %b actual %b", $time, want.out_last,
                     out_bus.out_last);
          end
        end
      end
    end
  end

  // receiver: random stall bursts plus a long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= 1'b1;
        if (gaps_on && $urandom_range(0, 4) == 0) begin
          stall_left = $urandom_range(1, 11);
        end
      end
    end
  end

  // one input transfer, with an optional gap in front
  task automatic send_item(input logic [7:0] b, input logic last);
    int gap;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_bus.valid   <= 1'b1;
    in_bus.in_byte <= b;
    in_bus.in_last <= last;
    do @(posedge clk_i); while (!in_bus.ready);
    apply_codec(b, last);
  endtask

  // stop sending, wait for all results, then let the pipeline settle
  task automatic drain;
    @(negedge clk_i);
    in_bus.valid   <= 1'b0;
    in_bus.in_last <= 1'b0;
    while (coded_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [AddrW-1:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    // direction write abandons any partial group
    if (addr == DirAddr) begin
      cur_dir  = data[0];
      grp_bits = '0;
      grp_cnt  = '0;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_direction;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= DirAddr;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {31'b0, cur_dir}) begin
      err_cnt++;
      $display("%0t: direction readback expected %h actual %h", $time,
               {31'b0, cur_dir}, prdata);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // register writes, readback and a write to an unused address
  task automatic test_register_access;
    check_direction();
    apb_write(DirAddr, {31'b0, DirDecode});
    check_direction();
    apb_write(SpareAddr, 32'h0000_0000);
    check_direction();
    apb_write(DirAddr, {31'h7FFF_FFFF, DirEncode});
    check_direction();
  endtask

  task automatic test_encode_directed;
    apb_write(DirAddr, {31'b0, DirEncode});
    // full group
    send_item(8'h4D, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(8'h6E, 1'b1);
    // plus characters, then one byte giving a slash, flushed with two pads
    send_item(8'hFB, 1'b0);
    send_item(8'hEF, 1'b0);
    send_item(8'hBE, 1'b0);
    send_item(8'hFF, 1'b1);
    // two bytes flushed with one pad
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b1);
    // partial group abandoned by a direction write
    send_item(8'h12, 1'b0);
    send_item(8'h34, 1'b0);
    drain();
    apb_write(DirAddr, {31'b0, DirEncode});
    send_item(8'h56, 1'b1);
    drain();
  endtask

  task automatic test_decode_directed;
    apb_write(DirAddr, {31'b0, DirDecode});
    send_item("T", 1'b0);
    send_item("W", 1'b0);
    send_item("F", 1'b0);
    send_item("u", 1'b0);
    // line breaks and pads skipped, end marker on a trailing pad
    send_item("T", 1'b0);
    send_item(CrChar, 1'b0);
    send_item("Q", 1'b0);
    send_item(LfChar, 1'b0);
    send_item(PadChar, 1'b0);
    send_item(PadChar, 1'b1);
    // invalid characters read as zero, digits eight and nine
    send_item(8'h2A, 1'b0);
    send_item(8'h80, 1'b0);
    send_item("8", 1'b0);
    send_item("9", 1'b0);
    // leftover sextet dropped at the end
    send_item(8'hFF, 1'b1);
    send_item(PlusChar, 1'b0);
    send_item(SlashChar, 1'b1);
    send_item(PadChar, 1'b1);
    drain();
  endtask

  task automatic test_random_encode(input int count);
    int sent;
    int len;
    bit cut;
    sent = 0;
    apb_write(DirAddr, {31'b0, DirEncode});
    while (sent < count) begin
      len = $urandom_range(1, 10);
      cut = ($urandom_range(0, 7) == 0);
      for (int i = 0; i < len; i++) begin
        send_item(8'($urandom_range(0, 255)), !cut && i == len - 1);
      end
      sent += len;
      if (cut) begin
        drain();
        apb_write(DirAddr, {31'b0, DirEncode});
      end
    end
    drain();
  endtask

  // mostly alphabet text, some line breaks and pads, some noise
  task automatic test_random_decode(input int count);
    int sent;
    int len;
    int pick;
    bit cut;
    logic [7:0] c;
    sent = 0;
    apb_write(DirAddr, {31'b0, DirDecode});
    while (sent < count) begin
      len = $urandom_range(1, 14);
      cut = ($urandom_range(0, 7) == 0);
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 78) begin
          c = sextet_char(6'($urandom_range(0, 63)));
        end else if (pick < 82) begin
          c = CrChar;
        end else if (pick < 86) begin
          c = LfChar;
        end else if (pick < 90) begin
          c = PadChar;
        end else begin
          c = 8'($urandom_range(0, 255));
        end
        send_item(c, !cut && i == len - 1);
      end
      sent += len;
      if (cut) begin
        drain();
        apb_write(DirAddr, {31'b0, DirDecode});
      end
    end
    drain();
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_input_backpressure;
    apb_write(DirAddr, {31'b0, DirDecode});
    hold_left = 80;
    for (int i = 0; i < 40; i++) begin
      send_item(sextet_char(6'($urandom_range(0, 63))), i == 39);
    end
    drain();
  endtask

  initial begin
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_bus.valid   = 1'b0;
    in_bus.in_byte = '0;
    in_bus.in_last = 1'b0;
    out_bus.ready  = 1'b0;
    cur_dir        = DirEncode;
    grp_bits       = '0;
    grp_cnt        = '0;
    err_cnt        = 0;
    gaps_on        = 1'b1;
    stall_left     = 0;
    hold_left      = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_register_access();
    test_encode_directed();
    test_decode_directed();
    test_random_encode(90);
    test_random_decode(90);
    test_input_backpressure();
    gaps_on = 1'b0;
    test_random_encode(40);
    test_random_decode(40);

    drain();
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/b64_pkg.sv
src/b64_if.sv
src/b64_step.sv
src/base64_codec_top.sv
verif/base64_codec_top_test.sv
